// File: hdl/hbp_pkg.sv
// Shared constants, command codes and types for the Huffman code bit packer.
// No dependencies; the top level, table, packer and result buffer import this package.
package hbp_pkg;

   // Table size and longest code held in one entry.
   localparam int NUM_SYMBOLS   = 256;
   localparam int MAX_CODE_BITS = 16;

   // Field widths of the input and result words.
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 16;
   localparam int CWID_W   = 5;
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int OFFS_W   = 32;
   localparam int IDX_W    = $clog2(NUM_SYMBOLS);
   localparam int ENTRY_W  = CWID_W + CODE_W;
   localparam int ACC_W    = BYTE_W + CODE_W;
   localparam int GROUP_N  = 3;

   // Input commands.
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   // Result kinds.
   localparam logic KIND_OFFSET = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   // Item after the table lookup; width is already zero for an empty entry.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CWID_W-1:0] width;
      logic [CODE_W-1:0] code;
   } hbp_item_type;

   // One result word.
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] out_byte;
      logic [OFFS_W-1:0] bit_offset;
      logic              last;
   } hbp_result_type;

   // All results caused by one item, entry 0 delivered first.
   typedef struct packed {
      logic [1:0]                      count;
      hbp_result_type [GROUP_N-1:0]    entry;
   } hbp_group_type;

endpackage

// File: hdl/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: table, packer and result buffer.
// Depends on hbp_pkg, hbp_table, hbp_packer and hbp_result_buf.
//
// The req channel carries commands: load writes one code table entry, encode
// looks a byte up and packs its code, flush sends the partial byte and two zero
// bytes and restarts the stream. The rsp channel returns offset records
// (tuser 0) and packed bytes (tuser 1), with tlast on the final word of an item.
// An item is taken every cycle while the result side keeps pace. An encode
// offers its first result after a registered table read and then packing into
// the result register, and gives one to three words; a flush gives two or
// three. The result port sends one word per cycle while rsp_tready is high,
// so the sustained item rate is one per cycle for loads and for encodes that
// give only an offset record; otherwise a group enters as the last one's final word leaves.
// Reset empties the pipeline, zeroes the pending byte and bit offset and marks
// every table width as zero; codes are left as they were.
// When the receiver stalls, the result buffer holds its group, the table stage
// holds one more item, and then req_tready drops.
module huffman_code_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // symbol[7:0], code_bits[23:8], code_width[28:24], zeros
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_byte[7:0], bit_offset[39:8]
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast
);
   import hbp_pkg::*;

   logic           item_valid;
   logic           item_ready;
   hbp_item_type   item;
   logic           group_valid;
   logic           group_ready;
   hbp_group_type  group;
   hbp_result_type result;

   // Input register and table lookup.
   hbp_table u_table (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_cmd        (req_tuser),
      .in_symbol     (req_tdata[7:0]),
      .in_code_bits  (req_tdata[23:8]),
      .in_code_width (req_tdata[28:24]),
      .out_valid     (item_valid),
      .out_ready     (item_ready),
      .out_item      (item)
   );

   // Bit packing and result formation.
   hbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_valid),
      .in_ready  (item_ready),
      .in_item   (item),
      .out_valid (group_valid),
      .out_ready (group_ready),
      .out_group (group)
   );

   // Result register toward the rsp channel.
   hbp_result_buf u_result_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (group_valid),
      .in_ready   (group_ready),
      .in_group   (group),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.bit_offset, result.out_byte};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule

// File: hdl/hbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/hbp_table.sv
// Input register and code table: writes loads, looks up encodes.
// Depends on hbp_pkg and hbp_ram.
module hbp_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [hbp_pkg::CMD_W-1:0]  in_cmd,
   input  logic [hbp_pkg::SYM_W-1:0]  in_symbol,
   input  logic [hbp_pkg::CODE_W-1:0] in_code_bits,
   input  logic [hbp_pkg::CWID_W-1:0] in_code_width,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hbp_pkg::hbp_item_type      out_item
);
   import hbp_pkg::*;

   logic                   accept;
   logic                   in_range;
   logic [IDX_W-1:0]       index;
   logic                   wr_en;
   logic [CWID_W-1:0]      sat_width;
   logic [ENTRY_W-1:0]     rd_data;
   logic [NUM_SYMBOLS-1:0] filled_ff;
   logic                   stage_valid_ff;
   logic                   hit_ff;
   logic [CMD_W-1:0]       cmd_ff;

   // The stage takes a word when empty or when its word moves on.
   assign in_ready = !stage_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   assign in_range = {1'b0, in_symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
   assign index    = in_symbol[IDX_W-1:0];
   assign wr_en    = accept && (in_cmd == CMD_LOAD) && in_range;

   // Widths above the longest code are clipped when loaded.
   assign sat_width = (in_code_width > CWID_W'(MAX_CODE_BITS)) ?
                      CWID_W'(MAX_CODE_BITS) : in_code_width;

   hbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (index),
      .wr_data ({sat_width, in_code_bits}),
      .rd_en   (accept),
      .rd_addr (index),
      .rd_data (rd_data)
   );

   // One flag per entry marks it as loaded since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (wr_en) begin
         filled_ff[index] <= 1'b1;
      end
   end

   // Stage register beside the registered RAM read.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (in_ready) begin
         stage_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= in_cmd;
         hit_ff <= in_range && filled_ff[index];
      end
   end

   // An entry never loaded reads as width zero.
   assign out_valid      = stage_valid_ff;
   assign out_item.cmd   = cmd_ff;
   assign out_item.width = hit_ff ? rd_data[ENTRY_W-1:CODE_W] : '0;
   assign out_item.code  = rd_data[CODE_W-1:0];

endmodule

// File: hdl/hbp_packer.sv
// Bit packer: merges a code into the pending byte and forms the result group.
// Depends on hbp_pkg.
module hbp_packer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hbp_pkg::hbp_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hbp_pkg::hbp_group_type out_group
);
   import hbp_pkg::*;

   logic [BYTE_W-1:0] bits_ff;
   logic [BYTE_W-1:0] bits_in;
   logic [2:0]        count_ff;
   logic [2:0]        count_in;
   logic [OFFS_W-1:0] pos_ff;
   logic [OFFS_W-1:0] pos_in;
   logic [CODE_W-1:0] code_masked;
   logic [ACC_W-1:0]  acc;
   logic [CWID_W-1:0] total;
   logic [1:0]        nbytes;
   logic              advance;

   // Code bits past the width are dropped, then placed after the pending bits.
   assign code_masked = in_item.code & ~({CODE_W{1'b1}} >> in_item.width);
   assign acc   = {bits_ff, {CODE_W{1'b0}}} | ({code_masked, {BYTE_W{1'b0}}} >> count_ff);
   assign total = {2'b00, count_ff} + in_item.width;
   assign nbytes = total[4:3];

   // Words without results pass at once; others wait for the result buffer.
   assign out_valid = in_valid && (out_group.count != 2'd0);
   assign in_ready  = out_ready || (out_group.count == 2'd0);
   assign advance   = in_valid && in_ready;

   // Result group and next packing state for the word in hand.
   always_comb begin
      out_group = '0;
      bits_in   = bits_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      case (in_item.cmd)
         CMD_ENCODE: begin
            out_group.count = 2'd1 + nbytes;
            out_group.entry[0] = '{kind: KIND_OFFSET, out_byte: '0,
                                   bit_offset: pos_ff, last: (nbytes == 2'd0)};
            out_group.entry[1] = '{kind: KIND_BYTE, out_byte: acc[ACC_W-1 -: BYTE_W],
                                   bit_offset: '0, last: (nbytes == 2'd1)};
            out_group.entry[2] = '{kind: KIND_BYTE, out_byte: acc[ACC_W-BYTE_W-1 -: BYTE_W],
                                   bit_offset: '0, last: 1'b1};
            case (nbytes)
               2'd0: begin
                  bits_in = acc[ACC_W-1 -: BYTE_W];
               end
               2'd1: begin
                  bits_in = acc[ACC_W-BYTE_W-1 -: BYTE_W];
               end
               default: begin
                  bits_in = acc[BYTE_W-1:0];
               end
            endcase
            count_in = total[2:0];
            pos_in   = pos_ff + OFFS_W'(in_item.width);
         end
         CMD_FLUSH: begin
            // A partial byte goes out first, then two zero bytes.
            if (count_ff != 3'd0) begin
               out_group.count = 2'd3;
               out_group.entry[0] = '{kind: KIND_BYTE, out_byte: bits_ff,
                                      bit_offset: '0, last: 1'b0};
               out_group.entry[1] = '{kind: KIND_BYTE, out_byte: '0,
                                      bit_offset: '0, last: 1'b0};
               out_group.entry[2] = '{kind: KIND_BYTE, out_byte: '0,
                                      bit_offset: '0, last: 1'b1};
            end else begin
               out_group.count = 2'd2;
               out_group.entry[0] = '{kind: KIND_BYTE, out_byte: '0,
                                      bit_offset: '0, last: 1'b0};
               out_group.entry[1] = '{kind: KIND_BYTE, out_byte: '0,
                                      bit_offset: '0, last: 1'b1};
            end
            bits_in  = '0;
            count_in = '0;
            pos_in   = '0;
         end
         default: begin
            // Loads and unused commands leave no result here.
            out_group.count = 2'd0;
         end
      endcase
   end

   // Packing state advances once per word, in order.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (advance) begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: hdl/hbp_result_buf.sv
// Result buffer: holds one group of up to three results and sends them in order.
// Depends on hbp_pkg.
module hbp_result_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hbp_pkg::hbp_group_type in_group,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hbp_pkg::hbp_result_type out_result
);
   import hbp_pkg::*;

   hbp_result_type [GROUP_N-1:0] entry_ff;
   logic [1:0]                   count_ff;
   logic                         take;

   assign out_valid  = (count_ff != 2'd0);
   assign out_result = entry_ff[0];
   assign take       = out_valid && out_ready;

   // A new group enters when the buffer is empty or its final word leaves now.
   assign in_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (in_valid && in_ready) begin
         count_ff <= in_group.count;
      end else if (take) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   // Words shift toward entry 0 as they are taken.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         entry_ff <= in_group.entry;
      end else if (take) begin
         entry_ff[0] <= entry_ff[1];
         entry_ff[1] <= entry_ff[2];
      end
   end

endmodule

// File: hdl/hbp_checker.sv
// Port-level checks for the Huffman code bit packer, bound to the top level.
// Depends on huffman_code_bit_packer for the bind target.
module hbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A command word that waits stays put.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) &&
      $stable(req_tuser))
      else $error("command word changed while waiting");

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // An offset record carries no byte.
   a_offset_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("offset record with nonzero byte");

   // A packed byte carries no offset.
   a_byte_no_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[39:8] == 32'h0)
      else $error("packed byte with nonzero offset");

endmodule

bind huffman_code_bit_packer hbp_checker u_checker (.*);
